// ----- rtl/core/smpq_pkg.sv -----
// Shared types, codes and constants for the sorted minimum priority queue.
// No dependencies; used by smpq_cell and sorted_min_priority_queue.
package smpq_pkg;

	localparam int DATA_W        = 32;
	localparam int COUNT_W       = 5;
	localparam int DEPTH_DEFAULT = 16;

	typedef enum logic {
		FUNC_INSERT = 1'b0,
		FUNC_REMOVE = 1'b1
	} func_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_FULL  = 2'd1,
		ERR_EMPTY = 2'd2
	} err_t;

	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

endpackage

// ----- rtl/core/smpq_cell.sv -----
// One slot of the sorted cell row; slot 0 holds the value removed next.
// Depends on smpq_pkg for the command struct and data width.
module smpq_cell import smpq_pkg::*; #(
	parameter int CntW = 5,
	parameter int Idx  = 0
) (
	input  logic                     clk,
	input  cmd_t                     cmd,
	input  logic [CntW-1:0]          fill,
	input  logic                     prev_lt,
	input  logic signed [DATA_W-1:0] prev_val,
	input  logic signed [DATA_W-1:0] next_val,
	output logic                     lt,
	output logic signed [DATA_W-1:0] val,
	output logic signed [DATA_W-1:0] val_nxt
);

	logic                     occupied;
	logic signed [DATA_W-1:0] val_q;

	assign occupied = CntW'(Idx) < fill;
	assign lt       = occupied && (val_q < cmd.value);
	assign val      = val_q;

	always_comb begin
		val_nxt = val_q;
		if (cmd.ins && !lt) begin
			val_nxt = prev_lt ? cmd.value : prev_val;
		end else if (cmd.rem) begin
			val_nxt = next_val;
		end
	end

	always_ff @(posedge clk) begin
		val_q <= val_nxt;
	end

endmodule

// ----- rtl/core/sorted_min_priority_queue.sv -----
// The queue accepts one request per cycle while in_ready is high and registers its result;
// all slots of the cell row update together, so in_ready drops only while a finished
// result waits at the output for out_ready. Equal values leave newest first.
// Top level of the sorted minimum priority queue; depends on smpq_pkg and smpq_cell.
module sorted_min_priority_queue import smpq_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     func,
	input  logic signed [DATA_W-1:0] item_value,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [DATA_W-1:0] removed_value,
	output logic signed [DATA_W-1:0] min_value,
	output logic [COUNT_W-1:0]       count,
	output logic                     full_res,
	output logic                     empty_res,
	output logic [1:0]               error
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic                     accept;
	logic                     is_full;
	logic                     is_empty;
	cmd_t                     cmd;
	err_t                     err_d;
	logic [CntW-1:0]          count_q;
	logic [CntW-1:0]          count_d;
	logic [CntW+COUNT_W-1:0]  count_ext;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] removed_q;
	logic signed [DATA_W-1:0] min_q;
	logic                     full_q;
	logic                     empty_q;
	err_t                     err_q;

	logic                     lt      [DEPTH];
	logic signed [DATA_W-1:0] val     [DEPTH];
	logic signed [DATA_W-1:0] val_nxt [DEPTH];

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign is_full  = count_q == CntW'(DEPTH);
	assign is_empty = count_q == '0;

	always_comb begin
		cmd.value = item_value;
		cmd.ins   = accept && (func == FUNC_INSERT) && !is_full;
		cmd.rem   = accept && (func == FUNC_REMOVE) && !is_empty;
		err_d     = ERR_OK;
		if (func == FUNC_INSERT && is_full) begin
			err_d = ERR_FULL;
		end else if (func == FUNC_REMOVE && is_empty) begin
			err_d = ERR_EMPTY;
		end
		count_d = count_q;
		if (cmd.ins) begin
			count_d = count_q + CntW'(1);
		end else if (cmd.rem) begin
			count_d = count_q - CntW'(1);
		end
	end

	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic                     p_lt;
		logic signed [DATA_W-1:0] p_val;
		logic signed [DATA_W-1:0] n_val;

		if (k == 0) begin : g_head
			assign p_lt  = 1'b1;
			assign p_val = '0;
		end else begin : g_body
			assign p_lt  = lt[k-1];
			assign p_val = val[k-1];
		end
		if (k == DEPTH - 1) begin : g_last
			assign n_val = '0;
		end else begin : g_mid
			assign n_val = val[k+1];
		end

		smpq_cell #(
			.CntW (CntW),
			.Idx  (k)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.fill     (count_q),
			.prev_lt  (p_lt),
			.prev_val (p_val),
			.next_val (n_val),
			.lt       (lt[k]),
			.val      (val[k]),
			.val_nxt  (val_nxt[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			removed_q <= cmd.rem ? val[0] : '0;
			min_q     <= (count_d == '0) ? '0 : val_nxt[0];
			full_q    <= count_d == CntW'(DEPTH);
			empty_q   <= count_d == '0;
			err_q     <= err_d;
		end
	end

	assign count_ext     = {{COUNT_W{1'b0}}, count_q};
	assign out_valid     = out_valid_q;
	assign removed_value = removed_q;
	assign min_value     = min_q;
	assign count         = count_ext[COUNT_W-1:0];
	assign full_res      = full_q;
	assign empty_res     = empty_q;
	assign error         = err_q;

`ifndef NO_ASSERTIONS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(DEPTH))
		else $error("Stored count exceeds capacity.");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (empty_q == (count_q == '0)))
		else $error("Empty flag disagrees with stored count.");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |=> count_q == $past(count_q) + CntW'(1))
		else $error("Insert did not raise the count.");

	a_full_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && err_q == ERR_FULL) |-> full_q)
		else $error("Full error reported while not full.");
`endif

endmodule
